>>> src/pda_pkg.sv
`default_nettype none
package pda_pkg;
    localparam logic [7:0] SYM_START  = 8'h7A;
    localparam logic [7:0] SYM_LAMBDA = 8'h6C;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_SYM   = 2'd2,
        OP_END   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_ALIVE    = 3'd1,
        ST_DEAD     = 3'd2,
        ST_ACCEPTED = 3'd3,
        ST_REJECTED = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        MODE_EMPTY = 2'd0,
        MODE_FINAL = 2'd1,
        MODE_BOTH  = 2'd2
    } t_mode;

    localparam logic [1:0] CFG_INIT  = 2'd0;
    localparam logic [1:0] CFG_FINAL = 2'd1;
    localparam logic [1:0] CFG_MODE  = 2'd2;
    localparam logic [1:0] CFG_COUNT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_TOPRD, S_TOPWAIT, S_SCAN, S_SCANWAIT, S_CHECK,
        S_PUSH, S_ENDRD, S_ENDWAIT, S_ENDCHK, S_OUT
    } t_fsm;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  entry_index;
        logic [7:0]  symbol;
        logic [3:0]  entry_from_state;
        logic [3:0]  entry_to_state;
        logic [7:0]  entry_stack_top;
        logic [2:0]  entry_push_count;
        logic [31:0] entry_push_symbols;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] current_state;
        logic [6:0] stack_level;
    } t_out_word;
endpackage
`default_nettype wire

>>> src/pda_if.sv
`default_nettype none
interface pda_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/pushdown_automaton_recognizer_core.sv
`default_nettype none
// Pushdown recognizer. Load words fill the transition table, a begin word
// starts a word on stack 'z', symbol words step the automaton, the end word
// reports accept/reject. One word in flight at a time; the core is ready only
// while idle. A symbol word scans the table one entry at a time (read, wait,
// compare) from entry 0 until the first hit, then pushes one slot per step
// (push count saturated at four, lambda slots included). A miss ends the scan
// after L searched entries (L = transition_count, at most TABLE_ENTRIES).
// A symbol on a dead word or an empty stack skips the table scan, and an end
// word skips its stack check when the word is dead or the stack is empty.
// The result sits in its own output register until taken. The next word can
// be accepted meanwhile, but its result waits in S_OUT.
module pushdown_automaton_recognizer_core
    import pda_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int STACK_DEPTH   = 64,
    parameter int MAX_PUSH      = 4,
    parameter int STATE_COUNT   = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    pda_if.sink         in_if,
    pda_if.source       out_if
);
    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int NP = (MAX_PUSH < 4) ? MAX_PUSH : 4;

    // config registers
    logic [3:0]  r_init;
    logic [15:0] r_final;
    logic [1:0]  r_mode;
    logic [6:0]  r_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0; r_final <= '0; r_mode <= '0; r_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INIT:  r_init  <= i_cfg_data[3:0];
                CFG_FINAL: r_final <= i_cfg_data;
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_COUNT: r_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // transition memory: letter,from,to,top,count,bytes
    logic [58:0] m_tab [TABLE_ENTRIES];
    logic [7:0]  m_stk [STACK_DEPTH];

    t_fsm        r_fsm, n_fsm;
    logic [7:0]  r_sym;
    logic [3:0]  r_q;
    logic [PW-1:0] r_sp;
    logic        r_dead;
    logic [10:0] r_idx;
    logic [58:0] r_ent;
    logic [7:0]  r_top;
    logic [2:0]  r_k;
    logic [2:0]  r_status;
    logic        r_ovalid;
    t_out_word   r_opay;

    logic [10:0] limit;
    assign limit = (32'(r_count) < TABLE_ENTRIES) ? 11'(r_count) : 11'(TABLE_ENTRIES);

    // entry field slices
    logic [7:0] e_let, e_top;
    logic [3:0] e_from, e_to;
    logic [2:0] e_cnt;
    logic [31:0] e_bytes;
    assign {e_let, e_from, e_to, e_top, e_cnt, e_bytes} = r_ent;
    logic hit;
    assign hit = (e_let == r_sym) && (e_from == r_q) &&
                 ((e_top == r_top) || (e_top == SYM_LAMBDA));
    logic [2:0] npush;
    assign npush = (e_cnt > 3'(NP)) ? 3'(NP) : e_cnt;
    logic [7:0] pbyte;
    assign pbyte = e_bytes[8*r_k[1:0] +: 8];
    logic fin;
    assign fin = (32'(r_q) < STATE_COUNT) ? r_final[r_q] : 1'b0;

    assign in_if.ready    = (r_fsm == S_IDLE);
    assign out_if.valid   = r_ovalid;
    assign out_if.payload = r_opay;

    // next state
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: if (in_if.valid) begin
                unique case (t_op'(in_if.payload.operation))
                    OP_LOAD, OP_BEGIN: n_fsm = S_OUT;
                    OP_SYM: n_fsm = S_TOPRD;
                    OP_END: n_fsm = S_ENDRD;
                    default: n_fsm = S_OUT;
                endcase
            end
            S_TOPRD:    n_fsm = (r_dead || r_sp == '0) ? S_OUT : S_TOPWAIT;
            S_TOPWAIT:  n_fsm = S_SCAN;
            S_SCAN:     n_fsm = (r_idx >= limit) ? S_OUT : S_SCANWAIT;
            S_SCANWAIT: n_fsm = S_CHECK;
            S_CHECK:    n_fsm = hit ? S_PUSH : S_SCAN;
            S_PUSH: if (r_k >= npush) n_fsm = S_OUT;
                    else if (pbyte != SYM_LAMBDA && 32'(r_sp) >= STACK_DEPTH)
                        n_fsm = S_OUT;
            S_ENDRD:    n_fsm = (r_dead || r_sp == '0) ? S_OUT : S_ENDWAIT;
            S_ENDWAIT:  n_fsm = S_ENDCHK;
            S_ENDCHK:   n_fsm = S_OUT;
            S_OUT:      n_fsm = (!r_ovalid || out_if.ready) ? S_IDLE : S_OUT;
            default:    n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fsm <= S_IDLE;
        else          r_fsm <= n_fsm;
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (r_fsm == S_IDLE && in_if.valid &&
            in_if.payload.operation == OP_LOAD &&
            32'(in_if.payload.entry_index) < TABLE_ENTRIES)
            m_tab[TW'(in_if.payload.entry_index)] <= {in_if.payload.symbol,
                in_if.payload.entry_from_state, in_if.payload.entry_to_state,
                in_if.payload.entry_stack_top, in_if.payload.entry_push_count,
                in_if.payload.entry_push_symbols};
        if (r_fsm == S_SCAN) r_ent <= m_tab[TW'(r_idx)];
    end

    logic [PW-1:0] sp_m1;
    assign sp_m1 = r_sp - 1'b1;
    always_ff @(posedge i_clk) begin
        if (r_fsm == S_IDLE && in_if.valid && in_if.payload.operation == OP_BEGIN)
            m_stk[0] <= SYM_START;
        else if (r_fsm == S_PUSH && r_k < npush && pbyte != SYM_LAMBDA &&
                 32'(r_sp) < STACK_DEPTH)
            m_stk[SW'(r_sp)] <= pbyte;
        if (r_fsm == S_TOPRD || r_fsm == S_ENDRD) r_top <= m_stk[SW'(sp_m1)];
    end

    // datapath and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0; r_sp <= '0; r_dead <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            // result register: load when free or being taken
            if (r_fsm == S_OUT && (!r_ovalid || out_if.ready)) begin
                r_ovalid <= 1'b1;
                r_opay   <= '{status: r_status, current_state: r_q,
                              stack_level: 7'(r_sp)};
            end else if (out_if.ready) r_ovalid <= 1'b0;
            unique case (r_fsm)
                S_IDLE: if (in_if.valid) begin
                    r_sym <= in_if.payload.symbol;
                    r_idx <= '0;
                    if (in_if.payload.operation == OP_LOAD) r_status <= ST_DONE;
                    if (in_if.payload.operation == OP_BEGIN) begin
                        r_q <= r_init; r_sp <= PW'(1); r_dead <= 1'b0;
                        r_status <= ST_ALIVE;
                    end
                end
                S_TOPRD: if (r_dead || r_sp == '0) begin
                    r_dead <= 1'b1; r_status <= ST_DEAD;
                end
                S_SCAN: if (r_idx >= limit) begin
                    r_dead <= 1'b1; r_status <= ST_DEAD;
                end
                S_CHECK: begin
                    r_idx <= r_idx + 1'b1;
                    if (hit) begin
                        r_q <= e_to; r_k <= '0;
                        if (e_top != SYM_LAMBDA) r_sp <= sp_m1;
                    end
                end
                S_PUSH: begin
                    if (r_k >= npush) r_status <= ST_ALIVE;
                    else if (pbyte != SYM_LAMBDA) begin
                        if (32'(r_sp) >= STACK_DEPTH) begin
                            r_dead <= 1'b1; r_status <= ST_OVERFLOW;
                        end else r_sp <= r_sp + 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                end
                S_ENDRD: begin
                    r_dead <= 1'b1;
                    if (r_dead) r_status <= ST_REJECTED;
                    else if (r_mode == MODE_FINAL)
                        r_status <= fin ? ST_ACCEPTED : ST_REJECTED;
                    else if (r_mode != MODE_EMPTY && r_mode != MODE_BOTH)
                        r_status <= ST_REJECTED;
                    else if (r_sp == '0) r_status <= ST_REJECTED;
                end
                S_ENDCHK: begin
                    if (r_mode == MODE_EMPTY || r_mode == MODE_BOTH) begin
                        if (r_top != SYM_START) r_status <= ST_REJECTED;
                        else begin
                            r_sp <= sp_m1;
                            r_status <= ((sp_m1 == '0) &&
                                (r_mode == MODE_EMPTY || fin)) ?
                                ST_ACCEPTED : ST_REJECTED;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none
module tb_top;
    import pda_pkg::*;

    localparam int          NUM_SLOTS  = 64;
    localparam int          STK_DEPTH  = 64;
    localparam int          CYCLE_CAP  = 1_500_000;
    localparam logic [7:0]  SYM_A      = 8'h41;
    localparam logic [7:0]  SYM_B      = 8'h42;
    localparam logic [7:0]  LET_A      = 8'h61;
    localparam logic [1:0]  MODE_NONE  = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    pda_if #(.T(t_in_word))  in_ch ();
    pda_if #(.T(t_out_word)) out_ch ();

    pushdown_automaton_recognizer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data),
        .in_if       (in_ch),
        .out_if      (out_ch)
    );

    // shadow automaton: transition table, stack and registers
    logic [7:0]  tt_letter [NUM_SLOTS];
    logic [3:0]  tt_from   [NUM_SLOTS];
    logic [3:0]  tt_to     [NUM_SLOTS];
    logic [7:0]  tt_top    [NUM_SLOTS];
    logic [2:0]  tt_pcnt   [NUM_SLOTS];
    logic [31:0] tt_push   [NUM_SLOTS];
    logic [7:0]  pda_stack [STK_DEPTH];
    int          pda_sp;
    logic [3:0]  pda_state;
    bit          pda_dead;
    logic [3:0]  reg_init;
    logic [15:0] reg_final;
    logic [1:0]  reg_mode;
    logic [6:0]  reg_count;

    t_out_word   verdict_q [$];
    t_out_word   want;
    int          mismatches;
    int          cycles;
    int          send_idle;
    int          recv_idle;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cidx;
        logic [15:0] cdata;
        t_in_word    w;
        bit          typed;
        t_out_word   res;
    } dir_row_t;

    dir_row_t dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // step the shadow automaton by one word and return its verdict
    function automatic t_out_word pda_step(t_in_word w);
        t_status    s;
        t_out_word  r;
        int         lim;
        int         hit;
        int         n;
        int         idx;
        logic [7:0] top;
        logic [7:0] b;
        bit         bad;
        bit         empty_ok;
        bit         ok;
        s = ST_DONE;
        case (t_op'(w.operation))
            OP_LOAD: begin
                idx = w.entry_index;
                tt_letter[idx] = w.symbol;
                tt_from[idx]   = w.entry_from_state;
                tt_to[idx]     = w.entry_to_state;
                tt_top[idx]    = w.entry_stack_top;
                tt_pcnt[idx]   = w.entry_push_count;
                tt_push[idx]   = w.entry_push_symbols;
                s = ST_DONE;
            end
            OP_BEGIN: begin
                pda_state = reg_init;
                pda_stack[0] = SYM_START;
                pda_sp = 1;
                pda_dead = 0;
                s = ST_ALIVE;
            end
            OP_SYM: begin
                if (pda_dead) begin
                    s = ST_DEAD;
                end else if (pda_sp == 0) begin
                    pda_dead = 1;
                    s = ST_DEAD;
                end else begin
                    top = pda_stack[pda_sp-1];
                    lim = (reg_count < NUM_SLOTS) ? reg_count : NUM_SLOTS;
                    hit = -1;
                    for (int i = 0; i < lim; i++) begin
                        if (hit < 0 && tt_letter[i] == w.symbol && tt_from[i] == pda_state &&
                            (tt_top[i] == top || tt_top[i] == SYM_LAMBDA))
                            hit = i;
                    end
                    if (hit < 0) begin
                        pda_dead = 1;
                        s = ST_DEAD;
                    end else begin
                        pda_state = tt_to[hit];
                        if (tt_top[hit] != SYM_LAMBDA) pda_sp--;
                        n = (tt_pcnt[hit] > 4) ? 4 : tt_pcnt[hit];
                        s = ST_ALIVE;
                        for (int k = 0; k < n; k++) begin
                            b = tt_push[hit][8*k +: 8];
                            if (s == ST_ALIVE && b != SYM_LAMBDA) begin
                                if (pda_sp >= STK_DEPTH) begin
                                    pda_dead = 1;
                                    s = ST_OVERFLOW;
                                end else begin
                                    pda_stack[pda_sp] = b;
                                    pda_sp++;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
                // end of word: accept rule, then the word is closed
                s = ST_REJECTED;
                if (!pda_dead) begin
                    pda_dead = 1;
                    bad = 0;
                    empty_ok = 0;
                    ok = 0;
                    if (reg_mode == MODE_EMPTY || reg_mode == MODE_BOTH) begin
                        if (pda_sp == 0 || pda_stack[pda_sp-1] != SYM_START) begin
                            bad = 1;
                        end else begin
                            pda_sp--;
                            empty_ok = (pda_sp == 0);
                        end
                    end
                    if (!bad) begin
                        case (reg_mode)
                            MODE_EMPTY: ok = empty_ok;
                            MODE_FINAL: ok = reg_final[pda_state];
                            MODE_BOTH:  ok = empty_ok && reg_final[pda_state];
                            default:    ok = 0;
                        endcase
                    end
                    s = ok ? ST_ACCEPTED : ST_REJECTED;
                end
            end
        endcase
        r.status        = s;
        r.current_state = pda_state;
        r.stack_level   = pda_sp[6:0];
        return r;
    endfunction

    function automatic t_in_word noise_word();
        t_in_word    w;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        w = raw[$bits(t_in_word)-1:0];
        return w;
    endfunction

    function automatic logic [7:0] pick_sym();
        case ($urandom_range(3))
            0:       return SYM_START;
            1:       return SYM_A;
            2:       return SYM_B;
            default: return SYM_LAMBDA;
        endcase
    endfunction

    // table entry over a small alphabet and state set, so that words go deep
    function automatic t_in_word entry_word(int idx, bit noisy);
        t_in_word w;
        w = noise_word();
        w.operation   = OP_LOAD;
        w.entry_index = idx[5:0];
        if (!noisy) begin
            w.symbol           = LET_A + 8'($urandom_range(3));
            w.entry_from_state = 4'($urandom_range(3));
            w.entry_to_state   = 4'($urandom_range(3));
            w.entry_stack_top  = pick_sym();
            w.entry_push_count = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                                          : 3'($urandom_range(4));
            for (int k = 0; k < 4; k++)
                w.entry_push_symbols[8*k +: 8] = pick_sym();
        end
        return w;
    endfunction

    function automatic t_in_word op_word(t_op op, logic [7:0] sym);
        t_in_word w;
        w = noise_word();
        w.operation = op;
        w.symbol    = sym;
        return w;
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [15:0] data);
        dir_row_t r;
        r.is_cfg = 1;
        r.cidx   = idx;
        r.cdata  = data;
        r.typed  = 0;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void add_item(t_in_word w, bit typed, t_status s,
                                     logic [3:0] st, logic [6:0] lvl);
        dir_row_t r;
        r.is_cfg = 0;
        r.w      = w;
        r.typed  = typed;
        r.res.status        = s;
        r.res.current_state = st;
        r.res.stack_level   = lvl;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic t_in_word load_word(int idx, logic [7:0] sym, logic [3:0] from,
                                           logic [3:0] to, logic [7:0] top,
                                           logic [2:0] pcnt, logic [31:0] push);
        t_in_word w;
        w = noise_word();
        w.operation          = OP_LOAD;
        w.entry_index        = idx[5:0];
        w.symbol             = sym;
        w.entry_from_state   = from;
        w.entry_to_state     = to;
        w.entry_stack_top    = top;
        w.entry_push_count   = pcnt;
        w.entry_push_symbols = push;
        return w;
    endfunction

    // wait until every verdict is back and the core has settled
    task automatic drain();
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_INIT:  reg_init  = data[3:0];
            CFG_FINAL: reg_final = data;
            CFG_MODE:  reg_mode  = data[1:0];
            default:   reg_count = data[6:0];
        endcase
    endtask

    // hand one word to the core; the verdict is predicted when it is taken
    task automatic send(t_in_word w, bit typed, t_out_word res);
        t_out_word p;
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        p = pda_step(w);
        verdict_q = {verdict_q, (typed ? res : p)};
    endtask

    task automatic send_pred(t_in_word w);
        t_out_word none;
        none = '0;
        send(w, 1'b0, none);
    endtask

    task automatic run_phase(int target, bit first_fill, bit pause_once);
        int sent;
        int r;
        int len;
        bit paused;
        sent = 0;
        paused = 0;
        if (first_fill) begin
            for (int i = 4; i < NUM_SLOTS; i++) begin
                send_pred(entry_word(i, $urandom_range(7) == 0));
                sent++;
            end
        end
        while (sent < target) begin
            if (pause_once && !paused && sent >= target / 2) begin
                in_ch.valid <= 1'b0;
                drain();
                paused = 1;
            end
            r = $urandom_range(99);
            if (r < 8) begin
                send_pred(entry_word($urandom_range(NUM_SLOTS - 1), $urandom_range(3) == 0));
                sent++;
            end else if (r < 15) begin
                send_pred(noise_word());
                sent++;
            end else begin
                send_pred(op_word(OP_BEGIN, 8'($urandom)));
                len = $urandom_range(24);
                for (int k = 0; k < len; k++) begin
                    send_pred(op_word(OP_SYM, ($urandom_range(9) == 0) ? 8'($urandom)
                                              : LET_A + 8'($urandom_range(3))));
                end
                if ($urandom_range(9) != 0)
                    send_pred(op_word(OP_END, 8'($urandom)));
                sent += len + 2;
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: status %0d state %0d level %0d",
                                 out_ch.payload.status, out_ch.payload.current_state,
                                 out_ch.payload.stack_level);
                end else begin
                    want = verdict_q.pop_front();
                    if (out_ch.payload.status !== want.status ||
                        out_ch.payload.current_state !== want.current_state ||
                        out_ch.payload.stack_level !== want.stack_level) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.status, want.current_state, want.stack_level,
                                     out_ch.payload.status, out_ch.payload.current_state,
                                     out_ch.payload.stack_level);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        mismatches    = 0;
        cycles        = 0;
        send_idle     = 7;
        recv_idle     = 77;
        pda_sp        = 0;
        pda_state     = '0;
        pda_dead      = 0;
        reg_init      = '0;
        reg_final     = '0;
        reg_mode      = '0;
        reg_count     = '0;

        // directed rows: reset state, extremes, lambda top, saturation, modes
        add_item(op_word(OP_SYM, LET_A), 1, ST_DEAD, 4'd0, 7'd0);
        add_item(op_word(OP_END, 8'h00), 1, ST_REJECTED, 4'd0, 7'd0);
        add_item(op_word(OP_BEGIN, 8'hFF), 1, ST_ALIVE, 4'd0, 7'd1);
        add_item(op_word(OP_SYM, LET_A), 1, ST_DEAD, 4'd0, 7'd1);
        add_item(op_word(OP_END, 8'h00), 1, ST_REJECTED, 4'd0, 7'd1);
        add_item(op_word(OP_BEGIN, 8'h00), 1, ST_ALIVE, 4'd0, 7'd1);
        add_item(op_word(OP_END, 8'hFF), 1, ST_ACCEPTED, 4'd0, 7'd0);
        add_item(load_word(0, LET_A, 4'd0, 4'd1, SYM_LAMBDA, 3'd7,
                           {SYM_A, SYM_A, SYM_LAMBDA, SYM_A}), 1, ST_DONE, 4'd0, 7'd0);
        add_item(load_word(1, LET_A + 8'd1, 4'd1, 4'd1, SYM_A, 3'd0, 32'h0),
                 1, ST_DONE, 4'd0, 7'd0);
        add_item(load_word(2, LET_A + 8'd2, 4'd1, 4'd3, SYM_START, 3'd1,
                           {24'h0, SYM_START}), 1, ST_DONE, 4'd0, 7'd0);
        add_item(load_word(3, 8'hFF, 4'd15, 4'd15, 8'h00, 3'd4, 32'hFFFF_FFFF),
                 1, ST_DONE, 4'd0, 7'd0);
        add_cfg(CFG_COUNT, 16'd4);
        add_cfg(CFG_FINAL, 16'h8008);
        add_cfg(CFG_MODE, 16'(MODE_BOTH));
        add_item(op_word(OP_BEGIN, 8'h00), 0, ST_DONE, 4'd0, 7'd0);
        add_item(op_word(OP_SYM, LET_A), 0, ST_DONE, 4'd0, 7'd0);
        for (int k = 0; k < 3; k++)
            add_item(op_word(OP_SYM, LET_A + 8'd1), 0, ST_DONE, 4'd0, 7'd0);
        add_item(op_word(OP_SYM, LET_A + 8'd2), 0, ST_DONE, 4'd0, 7'd0);
        add_item(op_word(OP_END, 8'h00), 0, ST_DONE, 4'd0, 7'd0);
        add_cfg(CFG_INIT, 16'd15);
        add_cfg(CFG_MODE, 16'(MODE_NONE));
        add_cfg(CFG_FINAL, 16'hFFFF);
        add_item(op_word(OP_BEGIN, 8'h00), 1, ST_ALIVE, 4'd15, 7'd1);
        add_item(op_word(OP_END, 8'h00), 1, ST_REJECTED, 4'd15, 7'd1);
        add_item(op_word(OP_SYM, LET_A), 1, ST_DEAD, 4'd15, 7'd1);
        add_cfg(CFG_MODE, 16'(MODE_FINAL));
        add_item(op_word(OP_BEGIN, 8'h00), 1, ST_ALIVE, 4'd15, 7'd1);
        add_item(op_word(OP_END, 8'h00), 1, ST_ACCEPTED, 4'd15, 7'd1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                in_ch.valid <= 1'b0;
                write_reg(dir_rows[i].cidx, dir_rows[i].cdata);
            end else begin
                send(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
            end
        end
        in_ch.valid <= 1'b0;

        // sender mostly busy, receiver mostly stalled; fill the rest of the table
        write_reg(CFG_INIT, 16'($urandom_range(3)));
        write_reg(CFG_FINAL, 16'($urandom));
        write_reg(CFG_MODE, 16'(MODE_EMPTY));
        write_reg(CFG_COUNT, 16'd4);
        run_phase(360, 1, 1);

        send_idle = 77;
        recv_idle = 7;
        write_reg(CFG_INIT, 16'($urandom_range(3)));
        write_reg(CFG_FINAL, 16'($urandom));
        write_reg(CFG_MODE, 16'(MODE_BOTH));
        write_reg(CFG_COUNT, 16'd127);
        run_phase(270, 0, 0);

        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_INIT, 16'd0);
        write_reg(CFG_FINAL, 16'($urandom));
        write_reg(CFG_MODE, 16'(MODE_FINAL));
        write_reg(CFG_COUNT, 16'd64);
        run_phase(270, 0, 0);

        drain();
        repeat (150) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
src/pda_pkg.sv
src/pda_if.sv
src/pushdown_automaton_recognizer_core.sv
verif/tb_top.sv
